@@ src/fcpr_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the framed CRC packet receiver.
// Used by fcpr_outq, fcpr_ctrl, the top module and the testbench; depends on nothing else.
`default_nettype none

package fcpr_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int STORE_AW = $clog2(STORE_DEPTH);
  localparam int CMP_W = ($clog2(STORE_DEPTH + 1) > 10) ? $clog2(STORE_DEPTH + 1) : 10;

  localparam int unsigned CRC_LEN = 2;
  localparam logic [15:0] CRC_SEED = 16'h0000;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int OQ_DEPTH = 3;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd1;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  localparam logic [2:0] ERR_PREAMBLE = 3'd0;
  localparam logic [2:0] ERR_BUSY = 3'd1;
  localparam logic [2:0] ERR_LONG = 3'd2;
  localparam logic [2:0] ERR_SHORT = 3'd3;
  localparam logic [2:0] ERR_CRC = 3'd4;
  localparam logic [2:0] ERR_LINE = 3'd5;

  typedef enum logic [2:0] {
    FUNC_BYTE    = 3'd0,
    FUNC_TIMEOUT = 3'd1,
    FUNC_LINE    = 3'd2,
    FUNC_READ    = 3'd3,
    FUNC_RELEASE = 3'd4
  } func_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_RX   = 4'b0100,
    PH_ERR  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] rx_byte;
    logic [3:0] line_fault;
    logic [7:0] read_index;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] error_code;
    logic [3:0] fault_bits;
    logic [7:0] frame_length;
    logic [7:0] read_data;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } ram_req_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/fcpr_if.sv @@
// Valid/ready channel interfaces for the input items and the result items.
// Depends on nothing; payload widths follow the item and result formats.
`default_nettype none

interface fcpr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] rx_byte;
  logic [3:0] line_fault;
  logic [7:0] read_index;

  modport source (output valid, func, rx_byte, line_fault, read_index, input ready);
  modport sink (input valid, func, rx_byte, line_fault, read_index, output ready);
endinterface

interface fcpr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] error_code;
  logic [3:0] fault_bits;
  logic [7:0] frame_length;
  logic [7:0] read_data;

  modport source (output valid, kind, error_code, fault_bits, frame_length, read_data,
                  input ready);
  modport sink (input valid, kind, error_code, fault_bits, frame_length, read_data,
                output ready);
endinterface

`default_nettype wire

@@ src/fcpr_ram.sv @@
// Generic single-write, single-read memory with a registered read port.
// Self-contained; used for the frame store.
`default_nettype none

module fcpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/fcpr_outq.sv @@
// Result queue that decouples the receiver pipeline from the output channel.
// Depends on fcpr_pkg for the result types and the queue depth.
`default_nettype none

module fcpr_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fcpr_pkg::push_t   push,
  input  wire logic              pop,
  output logic                   head_valid,
  output fcpr_pkg::result_t      head,
  output logic                   can_accept
);
  import fcpr_pkg::*;

  result_t               entry_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_W-1:0]   count_r, count_nxt;
  logic                  do_pop;

  assign head_valid = (count_r != '0);
  assign head = entry_r[rd_ptr_r];
  assign do_pop = head_valid && pop;
  assign can_accept = ({1'b0, count_r} + {{OQ_CNT_W{1'b0}}, push.valid})
                      <= (OQ_CNT_W + 1)'(OQ_DEPTH - 1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push.valid && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push.valid && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry_r[wr_ptr_r] <= push.res;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (count_r < OQ_CNT_W'(OQ_DEPTH)) || do_pop)
    else $error("result queue overflow");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!push.valid && !do_pop) |=> $stable(count_r))
    else $error("queue count changed without push or pop");

  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    can_accept |-> (count_r < OQ_CNT_W'(OQ_DEPTH)))
    else $error("accept allowed with full queue");

endmodule

`default_nettype wire

@@ src/fcpr_ctrl.sv @@
// Frame receive controller: phase tracking, length checks, CRC and frame store access.
// Depends on fcpr_pkg; drives the frame store memory and feeds the result queue.
`default_nettype none

module fcpr_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire fcpr_pkg::item_t               in_item,
  output logic                               in_ready,
  input  wire logic                          cfg_we,
  input  wire logic [fcpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fcpr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output fcpr_pkg::ram_req_t                 ram_req,
  input  wire logic [7:0]                    ram_rdata,
  input  wire logic                          q_can_accept,
  output fcpr_pkg::push_t                    push
);
  import fcpr_pkg::*;

  logic [7:0]  preamble_r;
  logic [8:0]  capacity_r;
  phase_t      phase_r, phase_nxt;
  logic        pm_r, pm_nxt;
  logic [7:0]  elen_r, elen_nxt;
  logic [8:0]  wpos_r, wpos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        occ_r, occ_nxt;

  logic        s1_valid_r, s1_valid_nxt;
  result_t     s1_res_r, s1_res_nxt;
  logic        s1_rd_r, s1_rd_nxt;

  logic              acc;
  logic [15:0]       crc_upd;
  logic [8:0]        wpos_inc;
  logic [8:0]        frame_end;
  logic [CMP_W-1:0]  cap_eff;
  logic [CMP_W-1:0]  need;
  logic              too_long;
  logic              idx_ok;

  assign in_ready = q_can_accept;
  assign acc = in_valid && in_ready;
  assign crc_upd = crc_byte(crc_r, in_item.rx_byte);
  assign wpos_inc = wpos_r + 9'd1;
  assign frame_end = {1'b0, elen_r} + 9'(CRC_LEN);
  assign cap_eff = (CMP_W'(capacity_r) > CMP_W'(STORE_DEPTH)) ? CMP_W'(STORE_DEPTH)
                                                               : CMP_W'(capacity_r);
  assign need = CMP_W'(in_item.rx_byte) + CMP_W'(CRC_LEN);
  assign too_long = need > cap_eff;
  assign idx_ok = 32'(in_item.read_index) < STORE_DEPTH;

  always_comb begin
    phase_nxt = phase_r;
    pm_nxt = pm_r;
    elen_nxt = elen_r;
    wpos_nxt = wpos_r;
    crc_nxt = crc_r;
    occ_nxt = occ_r;
    s1_valid_nxt = 1'b0;
    s1_res_nxt = '0;
    s1_rd_nxt = 1'b0;
    ram_req.we = 1'b0;
    ram_req.waddr = STORE_AW'(wpos_r);
    ram_req.wdata = in_item.rx_byte;
    ram_req.re = 1'b0;
    ram_req.raddr = STORE_AW'(in_item.read_index);
    if (acc) begin
      case (in_item.func)
        FUNC_BYTE: begin
          case (phase_r)
            PH_IDLE: begin
              pm_nxt = (in_item.rx_byte == preamble_r);
              phase_nxt = PH_LEN;
            end
            PH_LEN: begin
              elen_nxt = in_item.rx_byte;
              s1_valid_nxt = 1'b1;
              if (!pm_r || occ_r || too_long) begin
                phase_nxt = PH_ERR;
                s1_res_nxt.kind = KIND_ERROR;
                s1_res_nxt.error_code = !pm_r ? ERR_PREAMBLE : (occ_r ? ERR_BUSY : ERR_LONG);
              end else begin
                crc_nxt = CRC_SEED;
                wpos_nxt = '0;
                phase_nxt = PH_RX;
                s1_res_nxt.kind = KIND_START;
              end
            end
            PH_RX: begin
              ram_req.we = 32'(wpos_r) < STORE_DEPTH;
              crc_nxt = crc_upd;
              wpos_nxt = wpos_inc;
              if (wpos_inc >= frame_end) begin
                phase_nxt = PH_IDLE;
                s1_valid_nxt = 1'b1;
                if (crc_upd == 16'h0000) begin
                  occ_nxt = 1'b1;
                  s1_res_nxt.kind = KIND_DONE;
                  s1_res_nxt.frame_length = elen_r;
                end else begin
                  s1_res_nxt.kind = KIND_ERROR;
                  s1_res_nxt.error_code = ERR_CRC;
                end
              end
            end
            default: ;
          endcase
        end
        FUNC_TIMEOUT: begin
          if (phase_r == PH_LEN || phase_r == PH_RX) begin
            s1_valid_nxt = 1'b1;
            s1_res_nxt.kind = KIND_ERROR;
            s1_res_nxt.error_code = ERR_SHORT;
          end
          phase_nxt = PH_IDLE;
        end
        FUNC_LINE: begin
          if (phase_r != PH_ERR) begin
            phase_nxt = PH_ERR;
            s1_valid_nxt = 1'b1;
            s1_res_nxt.kind = KIND_ERROR;
            s1_res_nxt.error_code = ERR_LINE;
            s1_res_nxt.fault_bits = in_item.line_fault;
          end
        end
        FUNC_READ: begin
          s1_valid_nxt = 1'b1;
          s1_res_nxt.kind = KIND_READ;
          s1_rd_nxt = idx_ok;
          ram_req.re = idx_ok;
        end
        FUNC_RELEASE: begin
          occ_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_r <= '0;
      capacity_r <= 9'(256);
      phase_r <= PH_IDLE;
      pm_r <= 1'b0;
      elen_r <= '0;
      wpos_r <= '0;
      crc_r <= CRC_SEED;
      occ_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s1_rd_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_PREAMBLE) begin
        preamble_r <= cfg_wdata[7:0];
      end
      if (cfg_we && cfg_index == REG_CAPACITY) begin
        capacity_r <= cfg_wdata[8:0];
      end
      phase_r <= phase_nxt;
      pm_r <= pm_nxt;
      elen_r <= elen_nxt;
      wpos_r <= wpos_nxt;
      crc_r <= crc_nxt;
      occ_r <= occ_nxt;
      s1_valid_r <= s1_valid_nxt;
      s1_rd_r <= s1_rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_res_r <= s1_res_nxt;
  end

  always_comb begin
    push.valid = s1_valid_r;
    push.res = s1_res_r;
    push.res.read_data = s1_rd_r ? ram_rdata : 8'h00;
  end

  a_rx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RX) |-> (wpos_r < frame_end))
    else $error("write position ran past the frame end");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> (acc && phase_r == PH_RX))
    else $error("frame store written outside payload reception");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.re |=> (s1_valid_r && s1_rd_r && s1_res_r.kind == KIND_READ))
    else $error("store read without a matching read result");

  a_occ_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(occ_r) |-> (s1_valid_r && s1_res_r.kind == KIND_DONE))
    else $error("buffer marked occupied without a completed frame");

endmodule

`default_nettype wire

@@ src/framed_crc_packet_receiver.sv @@
// Framed CRC packet receiver: a result is registered in the controller, then queued.
// Throughput is one item per cycle unless the result queue is near full; the frame store
// memory takes one write or one read per item; a three-entry result queue holds results.
// Reset (synchronous, active low) clears the phase, flags, CRC and configuration;
// the frame store is not cleared and reads of unwritten entries are undefined.
// Depends on fcpr_pkg, fcpr_if, fcpr_ram, fcpr_outq and fcpr_ctrl.
`default_nettype none

module framed_crc_packet_receiver (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  fcpr_in_if.sink                            in_chan,
  fcpr_out_if.source                         out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [fcpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fcpr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fcpr_pkg::*;

  item_t    in_item;
  ram_req_t ram_req;
  logic [7:0] ram_rdata;
  push_t    push;
  logic     q_can_accept;
  logic     in_ready;
  logic     head_valid;
  result_t  head;

  assign in_item.func = in_chan.func;
  assign in_item.rx_byte = in_chan.rx_byte;
  assign in_item.line_fault = in_chan.line_fault;
  assign in_item.read_index = in_chan.read_index;
  assign in_chan.ready = in_ready;

  fcpr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_item      (in_item),
    .in_ready     (in_ready),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .ram_req      (ram_req),
    .ram_rdata    (ram_rdata),
    .q_can_accept (q_can_accept),
    .push         (push)
  );

  fcpr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  fcpr_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_chan.ready),
    .head_valid (head_valid),
    .head       (head),
    .can_accept (q_can_accept)
  );

  assign out_chan.valid = head_valid;
  assign out_chan.kind = head.kind;
  assign out_chan.error_code = head.error_code;
  assign out_chan.fault_bits = head.fault_bits;
  assign out_chan.frame_length = head.frame_length;
  assign out_chan.read_data = head.read_data;

endmodule

`default_nettype wire

@@ tb/framed_crc_packet_receiver_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for framed_crc_packet_receiver: directed frames, then random
// frames, reads, releases and line noise under several register settings.
// Depends on fcpr_pkg, fcpr_if and the receiver RTL.

module framed_crc_packet_receiver_test;
  import fcpr_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic hold_off = 1'b0;

  fcpr_in_if in_ch();
  fcpr_out_if out_ch();

  framed_crc_packet_receiver uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_ch),
    .out_chan(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  item_t pending_items[$];
  result_t expected_results[$];
  result_t next_due;
  int queued_count = 0;
  int accepted_count = 0;
  int results_seen = 0;
  int fail_count = 0;
  int cycle_count = 0;
  bit resync_needed = 1'b0;

  logic [7:0] cfg_preamble = 8'h00;
  logic [8:0] cfg_capacity = 9'd256;
  phase_t rx_phase = PH_IDLE;
  logic preamble_ok = 1'b0;
  logic [7:0] want_len = 8'h00;
  logic [8:0] write_pos = 9'd0;
  logic [15:0] crc_acc = 16'h0000;
  logic occupied = 1'b0;
  logic [7:0] store_image [STORE_DEPTH];
  bit stored_seen [STORE_DEPTH];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic int eff_cap();
    return (cfg_capacity > STORE_DEPTH) ? STORE_DEPTH : int'(cfg_capacity);
  endfunction

  function automatic bit may_idle();
    return !(accepted_count >= 700 && accepted_count < 1000) && $urandom_range(0, 99) < 14;
  endfunction

  task automatic log_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 60) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  task automatic step_receiver(input item_t it);
    result_t r;
    bit emit;
    r = '0;
    emit = 1'b0;
    case (it.func)
      FUNC_BYTE: begin
        case (rx_phase)
          PH_IDLE: begin
            preamble_ok = (it.rx_byte == cfg_preamble);
            rx_phase = PH_LEN;
          end
          PH_LEN: begin
            want_len = it.rx_byte;
            emit = 1'b1;
            r.kind = KIND_ERROR;
            rx_phase = PH_ERR;
            if (!preamble_ok) begin
              r.error_code = ERR_PREAMBLE;
            end else if (occupied) begin
              r.error_code = ERR_BUSY;
            end else if (int'(it.rx_byte) + CRC_LEN > eff_cap()) begin
              r.error_code = ERR_LONG;
            end else begin
              r.kind = KIND_START;
              crc_acc = CRC_SEED;
              write_pos = 9'd0;
              rx_phase = PH_RX;
            end
          end
          PH_RX: begin
            if (write_pos < STORE_DEPTH) begin
              store_image[write_pos[7:0]] = it.rx_byte;
              stored_seen[write_pos[7:0]] = 1'b1;
            end
            crc_acc = crc16_step(crc_acc, it.rx_byte);
            write_pos = write_pos + 9'd1;
            if (write_pos >= want_len + CRC_LEN) begin
              rx_phase = PH_IDLE;
              emit = 1'b1;
              if (crc_acc == 16'h0000) begin
                occupied = 1'b1;
                r.kind = KIND_DONE;
                r.frame_length = want_len;
              end else begin
                r.kind = KIND_ERROR;
                r.error_code = ERR_CRC;
              end
            end
          end
          default: ;
        endcase
      end
      FUNC_TIMEOUT: begin
        if (rx_phase == PH_LEN || rx_phase == PH_RX) begin
          emit = 1'b1;
          r.kind = KIND_ERROR;
          r.error_code = ERR_SHORT;
        end
        rx_phase = PH_IDLE;
      end
      FUNC_LINE: begin
        if (rx_phase != PH_ERR) begin
          emit = 1'b1;
          r.kind = KIND_ERROR;
          r.error_code = ERR_LINE;
          r.fault_bits = it.line_fault;
          rx_phase = PH_ERR;
        end
      end
      FUNC_READ: begin
        emit = 1'b1;
        r.kind = KIND_READ;
        r.read_data = store_image[it.read_index];
      end
      FUNC_RELEASE: begin
        occupied = 1'b0;
      end
      default: ;
    endcase
    if (emit) begin
      expected_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        step_receiver({in_ch.func, in_ch.rx_byte, in_ch.line_fault, in_ch.read_index});
        accepted_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && !may_idle()) begin
          in_ch.valid <= 1'b1;
          in_ch.func <= pending_items[0].func;
          in_ch.rx_byte <= pending_items[0].rx_byte;
          in_ch.line_fault <= pending_items[0].line_fault;
          in_ch.read_index <= pending_items[0].read_index;
          void'(pending_items.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          log_mismatch($sformatf("result %0d arrived with none expected", results_seen));
        end else begin
          next_due = expected_results.pop_front();
          if (out_ch.kind !== next_due.kind)
            log_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                   results_seen, out_ch.kind, next_due.kind));
          if (out_ch.error_code !== next_due.error_code)
            log_mismatch($sformatf("result %0d error_code %0d, expected %0d",
                                   results_seen, out_ch.error_code, next_due.error_code));
          if (out_ch.fault_bits !== next_due.fault_bits)
            log_mismatch($sformatf("result %0d fault_bits %h, expected %h",
                                   results_seen, out_ch.fault_bits, next_due.fault_bits));
          if (out_ch.frame_length !== next_due.frame_length)
            log_mismatch($sformatf("result %0d frame_length %0d, expected %0d",
                                   results_seen, out_ch.frame_length, next_due.frame_length));
          if (out_ch.read_data !== next_due.read_data)
            log_mismatch($sformatf("result %0d read_data %h, expected %h",
                                   results_seen, out_ch.read_data, next_due.read_data));
        end
      end
      out_ch.ready <= !hold_off && !may_idle();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    while (accepted_count < 1200) @(posedge clk);
    hold_off <= 1'b1;
    repeat (60) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic item_t rand_item(input logic [2:0] f);
    item_t it;
    it.func = f;
    it.rx_byte = 8'($urandom);
    it.line_fault = 4'($urandom);
    it.read_index = 8'($urandom);
    return it;
  endfunction

  function automatic int pick_stored();
    int start;
    start = $urandom_range(0, STORE_DEPTH - 1);
    for (int k = 0; k < STORE_DEPTH; k++) begin
      if (stored_seen[(start + k) % STORE_DEPTH]) begin
        return (start + k) % STORE_DEPTH;
      end
    end
    return -1;
  endfunction

  task automatic push_item(input item_t it);
    while (pending_items.size() >= 8) @(posedge clk);
    pending_items.push_back(it);
    queued_count++;
  endtask

  task automatic push_simple(input logic [2:0] f);
    push_item(rand_item(f));
  endtask

  task automatic push_byte(input logic [7:0] b);
    item_t it;
    it = rand_item(FUNC_BYTE);
    it.rx_byte = b;
    push_item(it);
  endtask

  task automatic push_line(input logic [3:0] fault);
    item_t it;
    it = rand_item(FUNC_LINE);
    it.line_fault = fault;
    push_item(it);
  endtask

  task automatic push_read(input int idx);
    item_t it;
    it = rand_item(FUNC_READ);
    it.read_index = 8'(idx);
    if (idx >= 0) begin
      push_item(it);
    end
  endtask

  task automatic settle();
    while (accepted_count != queued_count || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PREAMBLE) begin
      cfg_preamble = val[7:0];
    end else begin
      cfg_capacity = val;
    end
  endtask

  task automatic push_frame(input int len, input int mode);
    logic [7:0] body[$];
    logic [15:0] c;
    int cut;
    int pos;
    c = CRC_SEED;
    for (int i = 0; i < len; i++) begin
      body.push_back(8'($urandom));
      c = crc16_step(c, body[i]);
    end
    body.push_back(c[15:8]);
    body.push_back(c[7:0]);
    if (mode >= 70 && mode < 82) begin
      pos = $urandom_range(0, len + 1);
      body[pos] = body[pos] ^ 8'(1 << $urandom_range(0, 7));
    end
    cut = (mode >= 82) ? $urandom_range(0, len + 1) : len + 2;
    push_byte(cfg_preamble);
    push_byte(8'(len));
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        push_read(pick_stored());
      end
      push_byte(body[i]);
    end
    if (mode >= 92) begin
      push_line(4'($urandom));
    end
    if (mode >= 82) begin
      push_simple(FUNC_TIMEOUT);
    end
  endtask

  task automatic run_phase(input logic [7:0] pre, input logic [8:0] cap, input int budget,
                           input bit max_frame, input bit over_length);
    int start_count;
    int roll;
    int maxlen;
    item_t it;
    write_reg(REG_PREAMBLE, {1'b0, pre});
    write_reg(REG_CAPACITY, cap);
    maxlen = eff_cap() - 2;
    start_count = queued_count;
    if (max_frame) begin
      push_simple(FUNC_TIMEOUT);
      push_simple(FUNC_RELEASE);
      push_frame(maxlen, 0);
    end
    if (over_length) begin
      push_simple(FUNC_TIMEOUT);
      push_simple(FUNC_RELEASE);
      push_byte(cfg_preamble);
      push_byte(8'hFF);
      push_simple(FUNC_TIMEOUT);
    end
    while (queued_count - start_count < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        if (resync_needed || $urandom_range(0, 3) == 0) begin
          push_simple(FUNC_TIMEOUT);
          resync_needed = 1'b0;
        end
        if ($urandom_range(0, 3) != 0) begin
          push_simple(FUNC_RELEASE);
        end else begin
          resync_needed = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
          push_frame($urandom_range(0, maxlen), $urandom_range(0, 99));
        end else begin
          push_frame($urandom_range(0, (maxlen < 12) ? maxlen : 12), $urandom_range(0, 99));
        end
      end else if (roll < 70) begin
        if ($urandom_range(0, 1) == 1 && maxlen < 255) begin
          push_byte(cfg_preamble);
          push_byte(8'($urandom_range(maxlen + 1, 255)));
        end else begin
          push_byte(cfg_preamble ^ 8'($urandom_range(1, 255)));
          push_byte(8'($urandom));
        end
        push_simple(FUNC_TIMEOUT);
      end else if (roll < 85) begin
        repeat ($urandom_range(1, 3)) push_read(pick_stored());
      end else if (roll < 90) begin
        push_simple(FUNC_RELEASE);
      end else begin
        it = rand_item(3'($urandom_range(0, 7)));
        if (it.func == FUNC_READ) begin
          if (pick_stored() < 0) begin
            it.func = FUNC_RELEASE;
          end else begin
            it.read_index = 8'(pick_stored());
          end
        end
        push_item(it);
        resync_needed = 1'b1;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_BYTE;
    in_ch.rx_byte = 8'h00;
    in_ch.line_fault = 4'h0;
    in_ch.read_index = 8'h00;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_PREAMBLE, 9'h0A5);
    write_reg(REG_CAPACITY, 9'd256);
    push_simple(FUNC_TIMEOUT);
    push_simple(FUNC_SPARE_LO);
    push_simple(FUNC_SPARE_HI);
    push_byte(8'hA5);
    push_line(4'hF);
    push_line(4'h0);
    push_byte(8'h11);
    push_simple(FUNC_TIMEOUT);
    push_byte(8'hA5);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_read(1);
    push_byte(8'h3C);
    push_byte(8'hFF);
    push_simple(FUNC_TIMEOUT);
    push_byte(8'hA5);
    push_byte(8'hFF);
    push_simple(FUNC_TIMEOUT);
    push_simple(FUNC_RELEASE);
    push_byte(8'hA5);
    push_byte(8'hFF);
    push_simple(FUNC_TIMEOUT);
    push_byte(8'hA5);
    push_byte(8'h02);
    push_byte(8'hAB);
    push_simple(FUNC_TIMEOUT);
    push_byte(8'hA5);
    push_simple(FUNC_TIMEOUT);

    run_phase(8'h00, 9'd256, 290, 1'b1, 1'b0);
    run_phase(8'hFF, 9'd2, 290, 1'b0, 1'b0);
    run_phase(8'($urandom), 9'h1FF, 290, 1'b0, 1'b1);
    run_phase(8'($urandom), 9'($urandom_range(3, 40)), 290, 1'b0, 1'b0);
    run_phase(8'($urandom), 9'($urandom_range(100, 255)), 290, 1'b0, 1'b0);

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
